FILE: hw/rtl/trbc_pkg.sv
package trbc_pkg;

  localparam int DEPTH = 1024;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OFF_W = 10;
  localparam int CNT_W = 10;
  localparam int TAG_W = 8;
  localparam int DATA_W = 64;
  localparam int ENTRY_W = TAG_W + DATA_W;
  localparam int SUM_W = ((PTR_W > OFF_W) ? PTR_W : OFF_W) + 1;

  typedef logic [1:0] cmd_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cmd_t CMD_APPEND   = 2'd0;
  localparam cmd_t CMD_COMMIT   = 2'd1;
  localparam cmd_t CMD_ROLLBACK = 2'd2;
  localparam cmd_t CMD_READ     = 2'd3;

  typedef struct packed {
    ptr_t wr_addr;
    ptr_t rd_addr;
    logic hit;
    cnt_t committed_count;
    cnt_t held_count;
  } ptr_stat_t;

  function automatic ptr_t ring_next(ptr_t p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ring_dist(ptr_t from, ptr_t to);
    logic [PTR_W:0] t;
    t = {1'b0, to} + (PTR_W + 1)'(DEPTH) - {1'b0, from};
    if (to >= from) begin
      return to - from;
    end
    return t[PTR_W-1:0];
  endfunction

  function automatic cnt_t to_count(ptr_t d);
    return CNT_W'(d);
  endfunction

endpackage

FILE: hw/rtl/trbc_ptr_ctl.sv
module trbc_ptr_ctl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  trbc_pkg::cmd_t                 cmd,
  input  logic [trbc_pkg::OFF_W-1:0]     read_offset,
  output trbc_pkg::ptr_stat_t            stat
);
  import trbc_pkg::*;

  ptr_t write_ptr, read_ptr, commit_ptr;
  ptr_t write_ptr_next, read_ptr_next, commit_ptr_next;
  ptr_t wr_inc;
  ptr_t committed_cur;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] idx;

  always_comb begin
    write_ptr_next  = write_ptr;
    read_ptr_next   = read_ptr;
    commit_ptr_next = commit_ptr;
    wr_inc          = ring_next(write_ptr);
    unique case (cmd)
      CMD_APPEND: begin
        write_ptr_next = wr_inc;
        if (wr_inc == read_ptr) begin
          read_ptr_next = ring_next(read_ptr);
        end
        if (wr_inc == commit_ptr) begin
          commit_ptr_next = ring_next(commit_ptr);
        end
      end
      CMD_COMMIT:   commit_ptr_next = write_ptr;
      CMD_ROLLBACK: write_ptr_next = commit_ptr;
      CMD_READ: ;
      default: ;
    endcase
  end

  always_comb begin
    committed_cur = ring_dist(read_ptr, commit_ptr);
    sum = SUM_W'(read_ptr) + SUM_W'(read_offset);
    idx = (sum >= SUM_W'(DEPTH)) ? sum - SUM_W'(DEPTH) : sum;
    stat.wr_addr         = write_ptr;
    stat.rd_addr         = idx[PTR_W-1:0];
    stat.hit             = SUM_W'(read_offset) < SUM_W'(committed_cur);
    stat.committed_count = to_count(ring_dist(read_ptr_next, commit_ptr_next));
    stat.held_count      = to_count(ring_dist(read_ptr_next, write_ptr_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr  <= '0;
      read_ptr   <= '0;
      commit_ptr <= '0;
    end else if (step) begin
      write_ptr  <= write_ptr_next;
      read_ptr   <= read_ptr_next;
      commit_ptr <= commit_ptr_next;
    end
  end

  a_commit_within_held: assert property (@(posedge clk) disable iff (rst)
    ring_dist(read_ptr, commit_ptr) <= ring_dist(read_ptr, write_ptr))
    else $error("commit pointer outside held entries");

  a_rollback_empties_pending: assert property (@(posedge clk) disable iff (rst)
    step && cmd == CMD_ROLLBACK |=> write_ptr == commit_ptr)
    else $error("rollback left pending entries");

endmodule

FILE: hw/rtl/trace_ring_buffer_with_commit_unit.sv
// Circular trace buffer with commit pointer.
// Input channel (in_valid/in_ready) carries one command per transfer:
// append an entry, commit, roll back to the last commit, or read a
// committed entry at read_offset from the oldest held entry.
// Output channel (out_valid/out_ready) returns exactly one result per
// command: entry_valid, entry_tag and entry_payload for a read that hits
// a committed entry (zero otherwise), plus committed_count and held_count
// after the command.
// Throughput: one command per cycle while out_ready stays high; pointers
// update in the cycle of the transfer, so appends, commits and reads can
// follow one another back to back.
// Result path: the input transfer loads the read stage (s1, with the
// registered read port of the entry store), which then feeds the output
// register that drives out_valid and the result fields.
// Stall: a result waiting on out_ready holds in the output register while
// one more command is taken into the read stage; then in_ready drops.
// Reset: all pointers clear to zero (empty buffer); store contents are
// not cleared and become meaningful once written.
module trace_ring_buffer_with_commit_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  trbc_pkg::cmd_t                cmd,
  input  logic [trbc_pkg::TAG_W-1:0]    tag_code,
  input  logic [trbc_pkg::DATA_W-1:0]   payload,
  input  logic [trbc_pkg::OFF_W-1:0]    read_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          entry_valid,
  output logic [trbc_pkg::TAG_W-1:0]    entry_tag,
  output logic [trbc_pkg::DATA_W-1:0]   entry_payload,
  output trbc_pkg::cnt_t                committed_count,
  output trbc_pkg::cnt_t                held_count
);
  import trbc_pkg::*;

  logic                accept;
  logic                s1_adv;
  logic                we;
  logic                re;
  ptr_stat_t           stat;
  logic [ENTRY_W-1:0]  store [DEPTH];
  logic [ENTRY_W-1:0]  rd_data;
  logic                s1_valid;
  logic                s1_hit;
  cnt_t                s1_committed;
  cnt_t                s1_held;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;
  assign we       = accept && cmd == CMD_APPEND;
  assign re       = accept && cmd == CMD_READ && stat.hit;

  trbc_ptr_ctl u_ptr (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .cmd         (cmd),
    .read_offset (read_offset),
    .stat        (stat)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      store[stat.wr_addr] <= {tag_code, payload};
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= store[stat.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit       <= cmd == CMD_READ && stat.hit;
      s1_committed <= stat.committed_count;
      s1_held      <= stat.held_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      entry_valid     <= s1_hit;
      entry_tag       <= s1_hit ? rd_data[ENTRY_W-1:DATA_W] : '0;
      entry_payload   <= s1_hit ? rd_data[DATA_W-1:0] : '0;
      committed_count <= s1_committed;
      held_count      <= s1_held;
    end
  end

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !entry_valid |-> entry_tag == '0 && entry_payload == '0)
    else $error("result without hit carries entry data");

  a_no_overwrite_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> !accept)
    else $error("read stage overwritten while held");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |=> s1_valid && out_valid)
    else $error("result lost during stall");

endmodule
